// File: rtl/eds_pkg.sv
// Shared widths, command codes and controller/datapath signal groups of the event deadline scheduler.
package eds_pkg;

   localparam int NUM_TOKENS_DEF = 6;
   localparam int CMD_W          = 3;
   localparam int TOK_W          = 3;
   localparam int CYC_W          = 31;
   localparam int TIME_W         = 32;
   localparam int MASK_W         = 6;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADVANCE  = 3'd0,
      CMD_CHECK    = 3'd1,
      CMD_RESYNC   = 3'd2,
      CMD_SCHEDULE = 3'd3,
      CMD_REBASE   = 3'd4
   } cmd_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
      logic scan;
      logic load_out;
   } ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sched_pending;
      logic scan_last;
   } stat_type;

endpackage

// File: rtl/eds_ifs.sv
// Valid/ready channel interfaces for the scheduler's command and result words.
interface eds_req_if;
   logic                       valid;
   logic                       ready;
   logic [eds_pkg::CMD_W-1:0]  cmd;
   logic [eds_pkg::TOK_W-1:0]  token_index;
   logic [eds_pkg::CYC_W-1:0]  cycles;

   modport source (output valid, cmd, token_index, cycles, input ready);
   modport sink   (input valid, cmd, token_index, cycles, output ready);
endinterface

interface eds_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [eds_pkg::TIME_W-1:0] elapsed;
   logic                              negative_sync;
   logic [eds_pkg::MASK_W-1:0]        fire_mask;
   logic signed [eds_pkg::TIME_W-1:0] earliest_deadline;
   logic signed [eds_pkg::TIME_W-1:0] now_time;

   modport source (output valid, elapsed, negative_sync, fire_mask, earliest_deadline,
                   now_time, input ready);
   modport sink   (input valid, elapsed, negative_sync, fire_mask, earliest_deadline,
                   now_time, output ready);
endinterface

// File: rtl/event_deadline_scheduler_top.sv
// Top level of the event deadline scheduler: channel hookup of controller and datapath.
//
// The scheduler keeps a signed 32-bit timestamp and, for each of NUM_TOKENS subsystem
// tokens, a last-sync time and a next-event deadline, plus the minimum of all deadlines.
// Each command word on the req channel (advance, check, resync, schedule, rebase) yields
// exactly one result word on the rsp channel, in order. Commands are executed one at a
// time: a schedule with a valid token index also finds the new minimum by walking the
// deadline registers one entry per cycle through a single signed comparator. A finished
// result sits in an output register, so the next command word is taken while the
// previous result still waits on rsp. The control state, the timestamp, the minimum and
// the per-token times are cleared by reset; the command, result and output registers
// are not, and the block is ready once reset is released. Time arithmetic wraps in two's
// complement and all time comparisons are signed; the fire mask carries tokens 0 to 5 only.
module event_deadline_scheduler_top #(
   parameter int NUM_TOKENS = eds_pkg::NUM_TOKENS_DEF
) (
   input logic        clock,
   input logic        reset,
   eds_req_if.sink    req,
   eds_rsp_if.source  rsp
);

   eds_pkg::ctrl_type ctrl;
   eds_pkg::stat_type stat;

   eds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   eds_dp #(
      .NUM_TOKENS (NUM_TOKENS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .ctrl                  (ctrl),
      .stat                  (stat),
      .req_cmd               (req.cmd),
      .req_token_index       (req.token_index),
      .req_cycles            (req.cycles),
      .rsp_elapsed           (rsp.elapsed),
      .rsp_negative_sync     (rsp.negative_sync),
      .rsp_fire_mask         (rsp.fire_mask),
      .rsp_earliest_deadline (rsp.earliest_deadline),
      .rsp_now_time          (rsp.now_time)
   );

endmodule

// File: rtl/eds_ctrl.sv
// Sequencing state machine of the event deadline scheduler.
module eds_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  eds_pkg::stat_type stat,
   output eds_pkg::ctrl_type ctrl
);

   typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_SCAN, ST_DONE} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_DONE) && out_free);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      ctrl          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl.capture = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctrl.execute = 1'b1;
            state_in     = stat.sched_pending ? ST_SCAN : ST_DONE;
         end
         ST_SCAN: begin
            ctrl.scan = 1'b1;
            if (stat.scan_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               ctrl.load_out = 1'b1;
               rsp_valid_in  = 1'b1;
               if (req_valid) begin
                  ctrl.capture = 1'b1;
                  state_in     = ST_EXEC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      ctrl.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a word still waiting");

   a_accept_goes_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EXEC))
      else $error("accepted word not executed next cycle");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && stat.scan_last) |=> (state_ff == ST_DONE))
      else $error("minimum search did not finish");

endmodule

// File: rtl/eds_dp.sv
// Timestamp, per-token times, minimum search and result registers of the scheduler.
module eds_dp #(
   parameter int NUM_TOKENS = eds_pkg::NUM_TOKENS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  eds_pkg::ctrl_type                 ctrl,
   output eds_pkg::stat_type                 stat,
   input  logic [eds_pkg::CMD_W-1:0]         req_cmd,
   input  logic [eds_pkg::TOK_W-1:0]         req_token_index,
   input  logic [eds_pkg::CYC_W-1:0]         req_cycles,
   output logic signed [eds_pkg::TIME_W-1:0] rsp_elapsed,
   output logic                              rsp_negative_sync,
   output logic [eds_pkg::MASK_W-1:0]        rsp_fire_mask,
   output logic signed [eds_pkg::TIME_W-1:0] rsp_earliest_deadline,
   output logic signed [eds_pkg::TIME_W-1:0] rsp_now_time
);

   localparam int TW     = eds_pkg::TIME_W;
   localparam int IDX_W  = (NUM_TOKENS > 1) ? $clog2(NUM_TOKENS) : 1;
   localparam int MASK_N = (NUM_TOKENS < eds_pkg::MASK_W) ? NUM_TOKENS : eds_pkg::MASK_W;
   localparam logic [4:0] NT5 = 5'(NUM_TOKENS);

   logic [eds_pkg::CMD_W-1:0] cmd_ff;
   logic [eds_pkg::TOK_W-1:0] tok_ff;
   logic [eds_pkg::CYC_W-1:0] cyc_ff;

   logic signed [TW-1:0] now_ff, now_in;
   logic signed [TW-1:0] min_ff, min_in;
   logic signed [TW-1:0] ls_ff [NUM_TOKENS];
   logic signed [TW-1:0] ls_in [NUM_TOKENS];
   logic signed [TW-1:0] dl_ff [NUM_TOKENS];
   logic signed [TW-1:0] dl_in [NUM_TOKENS];
   logic [IDX_W-1:0]     scan_idx_ff, scan_idx_in;

   logic signed [TW-1:0]       res_elapsed_ff, res_elapsed_in;
   logic                       res_neg_ff, res_neg_in;
   logic [eds_pkg::MASK_W-1:0] res_mask_ff, res_mask_in;

   logic signed [TW-1:0]       out_elapsed_ff, out_earliest_ff, out_now_ff;
   logic                       out_neg_ff;
   logic [eds_pkg::MASK_W-1:0] out_mask_ff;

   logic [4:0]       tok_wide;
   logic [IDX_W-1:0] tok_idx;
   logic             tok_ok;
   logic signed [TW-1:0] dl_scan;

   assign tok_wide = {2'b00, tok_ff};
   assign tok_idx  = tok_wide[IDX_W-1:0];
   assign tok_ok   = tok_wide < NT5;
   assign dl_scan  = dl_ff[scan_idx_ff];

   assign stat.sched_pending = (cmd_ff == eds_pkg::CMD_SCHEDULE) && tok_ok;
   assign stat.scan_last     = (scan_idx_ff == IDX_W'(NUM_TOKENS - 1));

   always_comb begin
      now_in         = now_ff;
      min_in         = min_ff;
      ls_in          = ls_ff;
      dl_in          = dl_ff;
      scan_idx_in    = scan_idx_ff;
      res_elapsed_in = res_elapsed_ff;
      res_neg_in     = res_neg_ff;
      res_mask_in    = res_mask_ff;
      if (ctrl.execute) begin
         res_elapsed_in = '0;
         res_neg_in     = 1'b0;
         res_mask_in    = '0;
         scan_idx_in    = '0;
         unique case (cmd_ff)
            eds_pkg::CMD_ADVANCE: begin
               now_in = now_ff + $signed({1'b0, cyc_ff});
            end
            eds_pkg::CMD_CHECK: begin
               for (int i = 0; i < MASK_N; i++) begin
                  res_mask_in[i] = (now_ff >= dl_ff[i]);
               end
            end
            eds_pkg::CMD_RESYNC: begin
               if (tok_ok) begin
                  res_elapsed_in = now_ff - ls_ff[tok_idx];
                  res_neg_in     = res_elapsed_in[TW-1];
                  ls_in[tok_idx] = now_ff;
               end
            end
            eds_pkg::CMD_SCHEDULE: begin
               if (tok_ok) begin
                  dl_in[tok_idx] = now_ff + $signed({1'b0, cyc_ff});
               end
            end
            eds_pkg::CMD_REBASE: begin
               for (int i = 0; i < NUM_TOKENS; i++) begin
                  ls_in[i] = ls_ff[i] - now_ff;
                  dl_in[i] = dl_ff[i] - now_ff;
               end
               min_in = min_ff - now_ff;
               now_in = '0;
            end
            default: ;
         endcase
      end
      // One deadline per cycle through a single signed comparator.
      if (ctrl.scan) begin
         if (scan_idx_ff == '0 || dl_scan < min_ff) begin
            min_in = dl_scan;
         end
         scan_idx_in = scan_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff      <= '0;
         min_ff      <= '0;
         scan_idx_ff <= '0;
         for (int i = 0; i < NUM_TOKENS; i++) begin
            ls_ff[i] <= '0;
            dl_ff[i] <= '0;
         end
      end else begin
         now_ff      <= now_in;
         min_ff      <= min_in;
         scan_idx_ff <= scan_idx_in;
         ls_ff       <= ls_in;
         dl_ff       <= dl_in;
      end
   end

   always_ff @(posedge clock) begin
      res_elapsed_ff <= res_elapsed_in;
      res_neg_ff     <= res_neg_in;
      res_mask_ff    <= res_mask_in;
      if (ctrl.capture) begin
         cmd_ff <= req_cmd;
         tok_ff <= req_token_index;
         cyc_ff <= req_cycles;
      end
      if (ctrl.load_out) begin
         out_elapsed_ff  <= res_elapsed_ff;
         out_neg_ff      <= res_neg_ff;
         out_mask_ff     <= res_mask_ff;
         out_earliest_ff <= min_ff;
         out_now_ff      <= now_ff;
      end
   end

   assign rsp_elapsed           = out_elapsed_ff;
   assign rsp_negative_sync     = out_neg_ff;
   assign rsp_fire_mask         = out_mask_ff;
   assign rsp_earliest_deadline = out_earliest_ff;
   assign rsp_now_time          = out_now_ff;

   a_rebase_zeroes_now: assert property (@(posedge clock) disable iff (reset)
      (ctrl.execute && cmd_ff == eds_pkg::CMD_REBASE) |=> (now_ff == '0))
      else $error("timestamp not zero after rebase");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      ctrl.scan |-> (scan_idx_ff <= IDX_W'(NUM_TOKENS - 1)))
      else $error("minimum search index past last token");

endmodule
